### hdl/mss_pkg.sv
// Shared types for the minimum-swaps block: controller commands and datapath status.
`default_nettype none

package mss_pkg;

  // commands from the controller to the datapath
  typedef struct packed {
    logic acc;       // input word accepted: store it or flag overflow
    logic key_rd;    // read the value at rank row i, clear j and rank
    logic key_lat;   // latch the key, start the sweep at j = 0
    logic sweep;     // compare one stored value against the key
    logic rk_wr;     // write the origin entry, clear the visited mark of row i
    logic cyc_open;  // unvisited start found: count a cycle, pos <= i
    logic wk_rd;     // read the origin at pos, mark pos visited
    logic wk_chk;    // pos <= origin read back
    logic next_i;    // advance the scan index
    logic fin;       // load the result register, clear the per-set state
  } cmd_t;

  // status back to the controller
  typedef struct packed {
    logic j_end;     // sweep index reached the item count
    logic i_last;    // i is the last stored index
    logic visited;   // visited mark read back at i
    logic closed;    // walk came back to its start
    logic out_busy;  // result register holds a word that is not taken
  } sts_t;

endpackage

`default_nettype wire

### hdl/mss_if.sv
// Stream interfaces for the input words and the result words.
`default_nettype none

interface mss_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface mss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] swap_count;
  logic       overflow;

  modport source (output valid, output swap_count, output overflow, input ready);
  modport sink   (input valid, input swap_count, input overflow, output ready);
endinterface

`default_nettype wire

### hdl/min_swaps_to_sort_top.sv
// Top level: minimum swap count of a loaded set of signed values.
// After the closing word come ranking (one value RAM read per compare), the cycle
//   walk and the hand-off of the result to the output register.
// Words load one per cycle; a new set loads only after the previous set is handed off.
// Reset: synchronous, active low; clears counts, flags and the result valid. RAM
//   contents are not reset; visited marks are cleared row by row during ranking.
`default_nettype none

module min_swaps_to_sort_top #(
  parameter int MAX_ITEMS = 256
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  mss_in_if.sink         in_word,
  mss_out_if.source      out_word
);

  import mss_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic in_acc;

  // Input words are taken only in the load phase; a result left in the
  // output register does not block loading of the next set.
  assign in_word.ready = in_ready;
  assign in_acc        = in_word.valid && in_ready;

  // Controller sequences: load -> per-row rank sweep -> cycle scan/walk -> hand-off.
  mss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .in_last  (in_word.last),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  // Datapath holds the three RAMs and the result register; the swap count is
  // the item count minus the number of permutation cycles found.
  mss_dpath #(.MAX_ITEMS(MAX_ITEMS)) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_value       (in_word.value),
    .sts            (sts),
    .out_ready      (out_word.ready),
    .out_valid      (out_word.valid),
    .out_swap_count (out_word.swap_count),
    .out_overflow   (out_word.overflow)
  );

endmodule

`default_nettype wire

### hdl/mss_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/mss_ctrl.sv
// Controller state machine: load, rank sweep, cycle walk, result hand-off.
`default_nettype none

module mss_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_acc,
  input  wire logic          in_last,
  input  wire mss_pkg::sts_t sts,
  output      mss_pkg::cmd_t cmd,
  output      logic          in_ready
);

  import mss_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_KEY_RD  = 10'b00_0000_0010,
    S_KEY_LAT = 10'b00_0000_0100,
    S_SWEEP   = 10'b00_0000_1000,
    S_RK_WR   = 10'b00_0001_0000,
    S_SC_RD   = 10'b00_0010_0000,
    S_SC_CHK  = 10'b00_0100_0000,
    S_WK_RD   = 10'b00_1000_0000,
    S_WK_CHK  = 10'b01_0000_0000,
    S_FIN     = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.acc  = in_acc;
        if (in_acc && in_last) begin
          state_nxt = S_KEY_RD;
        end
      end
      S_KEY_RD: begin
        cmd.key_rd = 1'b1;
        state_nxt  = S_KEY_LAT;
      end
      S_KEY_LAT: begin
        cmd.key_lat = 1'b1;
        state_nxt   = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.j_end) begin
          state_nxt = S_RK_WR;
        end
      end
      S_RK_WR: begin
        cmd.rk_wr = 1'b1;
        state_nxt = sts.i_last ? S_SC_RD : S_KEY_RD;
      end
      S_SC_RD: begin
        state_nxt = S_SC_CHK;
      end
      S_SC_CHK: begin
        if (!sts.visited) begin
          cmd.cyc_open = 1'b1;
          state_nxt    = S_WK_RD;
        end else if (sts.i_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.next_i = 1'b1;
          state_nxt  = S_SC_RD;
        end
      end
      S_WK_RD: begin
        cmd.wk_rd = 1'b1;
        state_nxt = S_WK_CHK;
      end
      S_WK_CHK: begin
        cmd.wk_chk = 1'b1;
        if (!sts.closed) begin
          state_nxt = S_WK_RD;
        end else if (sts.i_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.next_i = 1'b1;
          state_nxt  = S_SC_RD;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef ASSERT_OFF
  // a finished walk must leave through the hand-off state before new words come in
  a_walk_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WK_CHK) && sts.closed && sts.i_last |=> (state_r == S_FIN))
    else $error("walk end did not reach hand-off");
  // the last word of a set always starts the rank sweep
  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last |=> (state_r == S_KEY_RD))
    else $error("closing word did not start ranking");
  // no input word is taken outside the load phase
  a_acc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc |-> in_ready)
    else $error("word accepted outside load phase");
`endif

endmodule

`default_nettype wire

### hdl/mss_dpath.sv
// Datapath: value, origin and visited RAMs, rank counters, cycle walker, result register.
`default_nettype none

module mss_dpath #(
  parameter int MAX_ITEMS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mss_pkg::cmd_t      cmd,
  input  wire logic signed [31:0] in_value,
  output      mss_pkg::sts_t      sts,
  input  wire logic               out_ready,
  output      logic               out_valid,
  output      logic [7:0]         out_swap_count,
  output      logic               out_overflow
);

  import mss_pkg::*;

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  // set state
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               ovf_r, ovf_nxt;
  // rank sweep
  logic [IDX_W-1:0]   i_r, i_nxt;
  logic [CNT_W-1:0]   j_r, j_nxt;
  logic [IDX_W-1:0]   jd_r, jd_nxt;
  logic [IDX_W-1:0]   rank_r, rank_nxt;
  logic signed [31:0] key_r, key_nxt;
  // cycle walk
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   cyc_r, cyc_nxt;
  // result register
  logic               oval_r, oval_nxt;
  logic [7:0]         swap_r, swap_nxt;
  logic               ofl_r, ofl_nxt;

  // RAM ports
  logic               vs_we;
  logic [IDX_W-1:0]   vs_raddr;
  logic signed [31:0] vs_rdata;
  logic               so_we;
  logic [IDX_W-1:0]   so_rdata;
  logic               vm_we;
  logic [IDX_W-1:0]   vm_waddr;
  logic               vm_wdata;
  logic               vm_rdata;

  logic               less;
  logic [CNT_W-1:0]   total;
  logic [CNT_W+7:0]   total_ext;

  mss_ram #(.WIDTH(32), .DEPTH(MAX_ITEMS)) u_value_ram (
    .clk   (clk),
    .we    (vs_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (in_value),
    .raddr (vs_raddr),
    .rdata (vs_rdata)
  );

  mss_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ITEMS)) u_origin_ram (
    .clk   (clk),
    .we    (so_we),
    .waddr (rank_r),
    .wdata (i_r),
    .raddr (pos_r),
    .rdata (so_rdata)
  );

  mss_ram #(.WIDTH(1), .DEPTH(MAX_ITEMS)) u_visited_ram (
    .clk   (clk),
    .we    (vm_we),
    .waddr (vm_waddr),
    .wdata (vm_wdata),
    .raddr (i_r),
    .rdata (vm_rdata)
  );

  assign vs_we    = cmd.acc && (cnt_r < CNT_W'(MAX_ITEMS));
  assign vs_raddr = cmd.key_rd ? i_r : j_r[IDX_W-1:0];
  assign so_we    = cmd.rk_wr;
  // rank pass clears the marks of live rows, the walk sets them
  assign vm_we    = cmd.rk_wr || cmd.wk_rd;
  assign vm_waddr = cmd.wk_rd ? pos_r : i_r;
  assign vm_wdata = cmd.wk_rd;

  // ties go to the earlier arrival
  assign less = (vs_rdata < key_r) || ((vs_rdata == key_r) && (jd_r < i_r));

  // swaps = items - cycles, saturated to eight bits
  assign total     = cnt_r - cyc_r;
  assign total_ext = {8'd0, total};

  assign sts.j_end    = (j_r == cnt_r);
  assign sts.i_last   = ((CNT_W'(i_r) + CNT_W'(1)) == cnt_r);
  assign sts.visited  = vm_rdata;
  assign sts.closed   = (so_rdata == i_r);
  assign sts.out_busy = oval_r && !out_ready;

  always_comb begin
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    jd_nxt   = jd_r;
    rank_nxt = rank_r;
    key_nxt  = key_r;
    pos_nxt  = pos_r;
    cyc_nxt  = cyc_r;
    oval_nxt = oval_r;
    swap_nxt = swap_r;
    ofl_nxt  = ofl_r;

    if (oval_r && out_ready) begin
      oval_nxt = 1'b0;
    end

    if (cmd.acc) begin
      if (vs_we) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    if (cmd.key_rd) begin
      j_nxt    = '0;
      rank_nxt = '0;
    end

    if (cmd.key_lat) begin
      key_nxt = vs_rdata;
      jd_nxt  = j_r[IDX_W-1:0];
      j_nxt   = j_r + CNT_W'(1);
    end

    if (cmd.sweep) begin
      if (less) begin
        rank_nxt = rank_r + IDX_W'(1);
      end
      if (!sts.j_end) begin
        jd_nxt = j_r[IDX_W-1:0];
        j_nxt  = j_r + CNT_W'(1);
      end
    end

    if (cmd.rk_wr) begin
      i_nxt = sts.i_last ? '0 : i_r + IDX_W'(1);
    end

    if (cmd.cyc_open) begin
      cyc_nxt = cyc_r + CNT_W'(1);
      pos_nxt = i_r;
    end

    if (cmd.wk_chk) begin
      pos_nxt = so_rdata;
    end

    if (cmd.next_i) begin
      i_nxt = i_r + IDX_W'(1);
    end

    if (cmd.fin) begin
      oval_nxt = 1'b1;
      swap_nxt = (total_ext > (CNT_W+8)'(255)) ? 8'hFF : total_ext[7:0];
      ofl_nxt  = ovf_r;
      cnt_nxt  = '0;
      ovf_nxt  = 1'b0;
      cyc_nxt  = '0;
      i_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      i_r    <= '0;
      j_r    <= '0;
      cyc_r  <= '0;
      oval_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
      i_r    <= i_nxt;
      j_r    <= j_nxt;
      cyc_r  <= cyc_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    jd_r   <= jd_nxt;
    rank_r <= rank_nxt;
    key_r  <= key_nxt;
    pos_r  <= pos_nxt;
    swap_r <= swap_nxt;
    ofl_r  <= ofl_nxt;
  end

  assign out_valid      = oval_r;
  assign out_swap_count = swap_r;
  assign out_overflow   = ofl_r;

`ifndef ASSERT_OFF
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ITEMS))
    else $error("item count beyond capacity");
  a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rk_wr |-> (CNT_W'(rank_r) < cnt_r))
    else $error("rank outside the loaded set");
  a_cyc_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wk_chk |-> (cyc_r != '0) && (cyc_r <= cnt_r))
    else $error("cycle count out of range during walk");
  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> oval_r && (cnt_r == '0))
    else $error("result not loaded at hand-off");
`endif

endmodule

`default_nettype wire
